/* hdl/edtc_pkg.sv */
package edtc_pkg;

  localparam int RawW   = 16;
  localparam int FixInW = 21;
  localparam int ValW   = 20;
  localparam int CmdW   = 4;
  localparam int StW    = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_BCD_DEC = 4'd0,
    CMD_BCD_ENC = 4'd1,
    CMD_D1B_DEC = 4'd2,
    CMD_D1B_ENC = 4'd3,
    CMD_D1C_DEC = 4'd4,
    CMD_D1C_ENC = 4'd5,
    CMD_D2B_DEC = 4'd6,
    CMD_D2B_ENC = 4'd7,
    CMD_D2C_DEC = 4'd8,
    CMD_D2C_ENC = 4'd9
  } cmd_t;

  typedef enum logic [StW-1:0] {
    ST_SUBST = 2'd0,
    ST_POS   = 2'd1,
    ST_NEG   = 2'd2
  } status_t;

  localparam logic [7:0]  SubstBcd   = 8'hFF;
  localparam logic [7:0]  SubstD1b   = 8'h80;
  localparam logic [7:0]  SubstD1c   = 8'hFF;
  localparam logic [7:0]  D1cMaxRaw  = 8'hC8;
  localparam logic [15:0] SubstD2    = 16'h8000;
  localparam logic [ValW-1:0] SubstVal255 = 20'd65280;

  // tens and ones digit of a value 0..99, reciprocal multiply by 205/2048
  function automatic logic [7:0] to_bcd(input logic [6:0] n);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = n * 8'd205;
    tens = prod[14:11];
    rem  = n - 7'(tens) * 7'd10;
    return {tens, rem[3:0]};
  endfunction

endpackage

/* hdl/ebus_data_type_codec_top.sv */
// channel   | dir | tdata (lsb up)                       | tuser
// s_axis    | in  | raw_word[15:0], fixed_value[36:16]   | cmd[3:0]
// m_axis    | out | raw_out[15:0], value_out[35:16]      | status[1:0]
//
// a beat accepted on s_axis is held in the input register, goes through one pass of
// conversion logic and is then held in the result register, where it is valid on m_axis
// one beat per cycle sustained while m_axis_tready is high; the conversion is a single combinational pass
// rst is synchronous and clears both valid flags; payload registers are not reset
// a stall on m_axis backs up through the input register, s_axis_tready drops
// only when both registers are full and m_axis_tready is low
module ebus_data_type_codec_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // raw_word, fixed_value, zero pad
  input  logic [3:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // raw_out, value_out, zero pad
  output logic [1:0]  m_axis_tuser   // status
);
  import edtc_pkg::*;

  logic                     in_valid;
  logic [CmdW-1:0]          cmd;
  logic [RawW-1:0]          word;
  logic signed [FixInW-1:0] fix;

  logic                     out_valid;
  logic [RawW-1:0]          raw_out;
  logic [ValW-1:0]          value_out;
  logic [StW-1:0]           status;

  logic                     out_ready;
  logic                     advance;

  logic [RawW-1:0]          raw_next;
  logic [ValW-1:0]          value_next;
  logic [StW-1:0]           status_next;

  logic [7:0]               lsb;
  logic signed [12:0]       n_int;   // floor of fixed_value
  logic [7:0]               bcd_bin;
  logic                     fix_neg;

  assign out_ready     = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_ready;
  assign s_axis_tready = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd  <= s_axis_tuser;
      word <= s_axis_tdata[15:0];
      fix  <= s_axis_tdata[36:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw_out   <= raw_next;
      value_out <= value_next;
      status    <= status_next;
    end
  end

  assign lsb     = word[7:0];
  assign n_int   = fix[20:8];
  assign fix_neg = fix[20];
  assign bcd_bin = {1'b0, lsb[7:4], 3'b000} + {3'b000, lsb[7:4], 1'b0} + {4'b0000, lsb[3:0]};

  always_comb begin
    raw_next    = '0;
    value_next  = '0;
    status_next = ST_SUBST;
    case (cmd)
      CMD_BCD_DEC: begin
        if (lsb[3:0] > 4'd9 || lsb[7:4] > 4'd9) begin
          value_next = SubstVal255;
        end else begin
          value_next  = {4'b0000, bcd_bin, 8'h00};
          status_next = ST_POS;
        end
      end
      CMD_BCD_ENC: begin
        if (n_int < 13'sd0 || n_int > 13'sd99) begin
          raw_next = {8'h00, SubstBcd};
        end else begin
          raw_next    = {8'h00, to_bcd(n_int[6:0])};
          status_next = ST_POS;
        end
      end
      CMD_D1B_DEC: begin
        value_next = {{4{lsb[7]}}, lsb, 8'h00};
        if (lsb == SubstD1b) begin
          status_next = ST_SUBST;
        end else begin
          status_next = lsb[7] ? ST_NEG : ST_POS;
        end
      end
      CMD_D1B_ENC: begin
        if (n_int < -13'sd127 || n_int > 13'sd127) begin
          raw_next = {8'h00, SubstD1b};
        end else begin
          raw_next    = {8'h00, n_int[7:0]};
          status_next = fix_neg ? ST_NEG : ST_POS;
        end
      end
      CMD_D1C_DEC: begin
        if (lsb > D1cMaxRaw) begin
          value_next = SubstVal255;
        end else begin
          value_next  = {5'b00000, lsb, 7'b0000000};
          status_next = ST_POS;
        end
      end
      CMD_D1C_ENC: begin
        // 100.0 is 25600 in 1/256 units
        if (fix_neg || fix > 21'sd25600) begin
          raw_next = {8'h00, SubstD1c};
        end else begin
          raw_next    = {8'h00, fix[14:7]};
          status_next = ST_POS;
        end
      end
      CMD_D2B_DEC: begin
        value_next = {{4{word[15]}}, word};
        if (word == SubstD2) begin
          status_next = ST_SUBST;
        end else begin
          status_next = word[15] ? ST_NEG : ST_POS;
        end
      end
      CMD_D2B_ENC: begin
        if (fix < -21'sd32767 || fix > 21'sd32767) begin
          raw_next = SubstD2;
        end else begin
          raw_next    = fix[15:0];
          status_next = fix_neg ? ST_NEG : ST_POS;
        end
      end
      CMD_D2C_DEC: begin
        value_next = {word, 4'b0000};
        if (word == SubstD2) begin
          status_next = ST_SUBST;
        end else begin
          status_next = word[15] ? ST_NEG : ST_POS;
        end
      end
      CMD_D2C_ENC: begin
        // floor to 1/16 units is an arithmetic shift by four
        if (fix < -21'sd524287 || fix > 21'sd524287) begin
          raw_next = SubstD2;
        end else begin
          raw_next    = fix[19:4];
          status_next = fix_neg ? ST_NEG : ST_POS;
        end
      end
      default: begin
        raw_next    = '0;
        value_next  = '0;
        status_next = ST_SUBST;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'h0, value_out, raw_out};
  assign m_axis_tuser  = status;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_SUBST || status == ST_POS || status == ST_NEG))
    else $error("status code out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("converted beat lost");

  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid))
    else $error("result beat without source beat");

endmodule
